### sv/bubble_sort_engine_defines.svh
// Assertion macros shared by the sorter RTL.
`ifndef BUBBLE_SORT_ENGINE_DEFINES_SVH
`define BUBBLE_SORT_ENGINE_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define BSE_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("sorter check failed");

// Consequent that must hold in the cycle after the antecedent.
`define BSE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorter sequence check failed");

`endif

### sv/bse_pkg.sv
package bse_pkg;

    localparam int DEPTH     = 32;
    localparam int KEY_WIDTH = 32;
    localparam int CNT_W     = $clog2(DEPTH + 1);

    typedef logic [KEY_WIDTH-1:0] key_t;

    typedef struct packed {
        logic [31:0] key_in;
        logic        set_end;
    } load_beat_t;

    typedef struct packed {
        logic [31:0] key_out;
        logic        final_key;
        logic        overflow;
    } res_beat_t;

    typedef struct packed {
        logic             load;
        logic             sort;
        logic             phase;
        logic             shift;
        logic [1:0]       mode;
        logic [CNT_W-1:0] count;
    } cell_ctrl_t;

    // order_mode: bit 0 selects signed, bit 1 selects descending
    localparam int MODE_SIGNED_BIT = 0;
    localparam int MODE_DESC_BIT   = 1;

    // True when a must move behind b under the given order.
    function automatic logic goes_after(key_t a, key_t b, logic [1:0] mode);
        key_t sa;
        key_t sb;
        sa = a;
        sb = b;
        if (mode[MODE_SIGNED_BIT])
        begin
            sa[KEY_WIDTH-1] = ~a[KEY_WIDTH-1];
            sb[KEY_WIDTH-1] = ~b[KEY_WIDTH-1];
        end
        if (mode[MODE_DESC_BIT])
            return sa < sb;
        return sa > sb;
    endfunction

endpackage

### sv/bse_cell.sv
module bse_cell import bse_pkg::*; (
    input  logic             clk,
    input  cell_ctrl_t       ctrl,
    input  logic [CNT_W-1:0] idx,
    input  key_t             load_key,
    input  key_t             left_key,
    input  key_t             right_key,
    input  logic             left_swap,
    output key_t             key,
    output logic             swap_right
);

    key_t key_reg;
    key_t key_next;
    logic [CNT_W-1:0] idx_plus;

    assign idx_plus = CNT_W'(idx + CNT_W'(1));

    // Odd-even transposition: this cell leads the pair when its index parity matches
    assign swap_right = ctrl.sort && (idx[0] == ctrl.phase) && (idx_plus < ctrl.count)
                        && goes_after(key_reg, right_key, ctrl.mode);

    always_comb
    begin
        if (swap_right)
            key_next = right_key;
        else if (left_swap)
            key_next = left_key;
        else if (ctrl.load && (idx == ctrl.count))
            key_next = load_key;
        else if (ctrl.shift)
            key_next = right_key;
        else
            key_next = key_reg;
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key = key_reg;

endmodule

### sv/bubble_sort_engine.sv
// Sorter built from a row of DEPTH key cells with odd-even transposition swaps.
// A set of n stored keys is loaded, sorted, then emitted one result per cycle while res_ready holds.
// After the closing beat the sort runs, then emission; no new set is taken until its last key is emitted.
// The sort round count follows the set size, one compare-swap round per cycle.
// rst_n is asynchronous, active low: clears control state and order_mode; no clearing pass.
`include "bubble_sort_engine_defines.svh"

module bubble_sort_engine import bse_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data,
    input  logic       load_valid,
    output logic       load_ready,
    input  load_beat_t load_data,
    output logic       res_valid,
    input  logic       res_ready,
    output res_beat_t  res_data
);

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_SORT = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] round_reg, round_next;
    logic             drop_reg, drop_next;
    logic [1:0]       mode_reg;
    logic [1:0]       sort_mode_reg, sort_mode_next;
    logic             res_valid_reg, res_valid_next;
    res_beat_t        res_data_reg, res_data_next;

    logic       load_take;
    logic       emit_take;
    logic       room;
    cell_ctrl_t ctrl;

    key_t cell_key [DEPTH];
    logic cell_swap [DEPTH];

    assign cfg_ready  = 1'b1;
    assign load_ready = (state_reg == ST_LOAD);
    assign load_take  = load_valid && load_ready;
    assign emit_take  = (state_reg == ST_EMIT) && (!res_valid_reg || res_ready);
    assign room       = (count_reg < CNT_W'(DEPTH));

    assign ctrl.load  = load_take && room;
    assign ctrl.sort  = (state_reg == ST_SORT);
    assign ctrl.phase = round_reg[0];
    assign ctrl.shift = emit_take;
    assign ctrl.mode  = sort_mode_reg;
    assign ctrl.count = count_reg;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            key_t left_k;
            key_t right_k;
            logic left_s;
            if (gi == 0)
            begin : g_first
                assign left_k = '0;
                assign left_s = 1'b0;
            end
            else
            begin : g_mid
                assign left_k = cell_key[gi-1];
                assign left_s = cell_swap[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_last
                assign right_k = '0;
            end
            else
            begin : g_inner
                assign right_k = cell_key[gi+1];
            end
            bse_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .idx        (CNT_W'(gi)),
                .load_key   (KEY_WIDTH'(load_data.key_in)),
                .left_key   (left_k),
                .right_key  (right_k),
                .left_swap  (left_s),
                .key        (cell_key[gi]),
                .swap_right (cell_swap[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        round_next     = round_reg;
        drop_next      = drop_reg;
        sort_mode_next = sort_mode_reg;
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;

        if (res_ready)
            res_valid_next = 1'b0;

        case (state_reg)
            ST_LOAD:
            begin
                if (load_take)
                begin
                    if (room)
                        count_next = CNT_W'(count_reg + CNT_W'(1));
                    else
                        drop_next = 1'b1;
                    if (load_data.set_end)
                    begin
                        state_next     = ST_SORT;
                        round_next     = '0;
                        sort_mode_next = mode_reg;
                    end
                end
            end
            ST_SORT:
            begin
                round_next = CNT_W'(round_reg + CNT_W'(1));
                if (round_next >= count_reg)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_take)
                begin
                    res_valid_next          = 1'b1;
                    res_data_next.key_out   = 32'(cell_key[0]);
                    res_data_next.final_key = (count_reg == CNT_W'(1));
                    res_data_next.overflow  = drop_reg;
                    count_next              = CNT_W'(count_reg - CNT_W'(1));
                    if (count_reg == CNT_W'(1))
                    begin
                        state_next = ST_LOAD;
                        drop_next  = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            round_reg     <= '0;
            drop_reg      <= 1'b0;
            mode_reg      <= 2'd0;
            sort_mode_reg <= 2'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            round_reg     <= round_next;
            drop_reg      <= drop_next;
            sort_mode_reg <= sort_mode_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid && cfg_ready)
                mode_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    `BSE_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(DEPTH))
    `BSE_ASSERT_ALWAYS(a_set_not_empty, (state_reg == ST_LOAD) || (count_reg != '0))
    `BSE_ASSERT_NEXT(a_final_closes, emit_take && (count_reg == CNT_W'(1)),
        (state_reg == ST_LOAD) && (count_reg == '0) && !drop_reg && res_data.final_key)
    `BSE_ASSERT_NEXT(a_result_held, res_valid && !res_ready, res_valid && $stable(res_data))

endmodule
